// File: rtl/core/dven_pkg.sv
// Shared widths, defaults and the store control bundle for the divisor enumerator.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package dven_pkg;

    localparam int MAX_FACTORS_DEF = 16;

    localparam int VAL_W  = 63;   // primes, multiple, divisor
    localparam int LIM_W  = 6;    // exponent limits and digits
    localparam int FC_W   = 5;    // factor_count register
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 4;    // factor_index field
    localparam int ADDR_W = 4;    // APB byte address
    localparam int DATA_W = 64;   // APB data

    // Control from the sequencer to the factor/digit store
    typedef struct packed {
        logic tab_we;   // load: write prime and limit
        logic dig_we;   // write back one exponent digit
        logic rd_en;    // read prime, limit and digit at one entry
        logic clear;    // restart: every digit back to zero
    } t_store_ctl;

endpackage

`default_nettype wire

// File: rtl/core/dven_regs.sv
// APB register file: factor_count and multiple, 64-bit data, registers at 8*i.
// Depends on dven_pkg for widths.
`default_nettype none

module dven_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [dven_pkg::ADDR_W-1:0]   i_paddr,
    input  wire logic [dven_pkg::DATA_W-1:0]   i_pwdata,
    output logic      [dven_pkg::DATA_W-1:0]   o_prdata,
    output logic      [dven_pkg::FC_W-1:0]     o_factor_count,
    output logic      [dven_pkg::VAL_W-1:0]    o_multiple
);

    localparam logic REG_FACTOR_COUNT = 1'b0;
    localparam logic REG_MULTIPLE     = 1'b1;

    logic                        w_wr;
    logic                        w_sel;
    logic [dven_pkg::FC_W-1:0]   r_factor_count;
    logic [dven_pkg::VAL_W-1:0]  r_multiple;

    assign w_wr  = i_psel && i_penable && i_pwrite;
    assign w_sel = i_paddr[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor_count <= dven_pkg::FC_W'(1);
            r_multiple     <= dven_pkg::VAL_W'(1);
        end else if (w_wr) begin
            unique case (w_sel)
                REG_FACTOR_COUNT: r_factor_count <= i_pwdata[dven_pkg::FC_W-1:0];
                REG_MULTIPLE:     r_multiple     <= i_pwdata[dven_pkg::VAL_W-1:0];
                default:          r_multiple     <= r_multiple;
            endcase
        end
    end

    always_comb begin
        unique case (w_sel)
            REG_FACTOR_COUNT: o_prdata = dven_pkg::DATA_W'(r_factor_count);
            REG_MULTIPLE:     o_prdata = dven_pkg::DATA_W'(r_multiple);
            default:          o_prdata = '0;
        endcase
    end

    assign o_factor_count = r_factor_count;
    assign o_multiple     = r_multiple;

endmodule

`default_nettype wire

// File: rtl/core/dven_mul.sv
// Saturating 63x63 multiplier built from one 32x32 multiplier over four partial products.
// Depends on dven_pkg. Result strobes on o_done once all four partial products are summed.
`default_nettype none

module dven_mul (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [dven_pkg::VAL_W-1:0]   i_a,
    input  wire logic [dven_pkg::VAL_W-1:0]   i_b,
    output logic                              o_done,
    output logic      [dven_pkg::VAL_W-1:0]   o_prod,
    output logic                              o_ovf
);

    localparam int          VW       = dven_pkg::VAL_W;
    localparam int          HW       = VW - 32;      // width of the upper half
    localparam int          AW       = 2 * VW;       // full product width
    localparam logic [2:0]  MUL_LAST = 3'd5;

    logic           r_busy;
    logic [2:0]     r_cnt;
    logic [VW-1:0]  r_a;
    logic [VW-1:0]  r_b;
    logic [63:0]    r_pp;
    logic [1:0]     r_sh;
    logic [AW-1:0]  r_acc;
    logic [31:0]    w_x;
    logic [31:0]    w_y;
    logic [63:0]    w_pp;
    logic [AW-1:0]  w_add;

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin
                w_x = r_a[31:0];
                w_y = r_b[31:0];
            end
            2'd1: begin
                w_x = r_a[31:0];
                w_y = 32'(r_b[VW-1:32]);
            end
            2'd2: begin
                w_x = 32'(r_a[VW-1:32]);
                w_y = r_b[31:0];
            end
            default: begin
                w_x = 32'(r_a[VW-1:32]);
                w_y = 32'(r_b[VW-1:32]);
            end
        endcase
    end

    assign w_pp = w_x * w_y;

    // partial product weight follows the step it came from
    always_comb begin
        unique case (r_sh)
            2'd0:    w_add = AW'(r_pp);
            2'd1,
            2'd2:    w_add = {{(AW-96){1'b0}}, r_pp, 32'b0};
            default: w_add = {r_pp[2*HW-1:0], 64'b0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 3'd1;
            if (r_cnt == MUL_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_pp <= w_pp;
            r_sh <= r_cnt[1:0];
            if (r_cnt != 3'd0 && r_cnt != MUL_LAST) begin
                r_acc <= r_acc + w_add;
            end
        end
    end

    assign o_done = r_busy && (r_cnt == MUL_LAST);
    assign o_ovf  = |r_acc[AW-1:VW];
    assign o_prod = o_ovf ? {VW{1'b1}} : r_acc[VW-1:0];

endmodule

`default_nettype wire

// File: rtl/core/dven_div.sv
// Restoring divider, one quotient bit per cycle, 63-bit operands.
// Depends on dven_pkg. Quotient strobes on o_done after the last bit; divisor must be non-zero.
`default_nettype none

module dven_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [dven_pkg::VAL_W-1:0]   i_num,
    input  wire logic [dven_pkg::VAL_W-1:0]   i_den,
    output logic                              o_done,
    output logic      [dven_pkg::VAL_W-1:0]   o_quot
);

    localparam int                      VW   = dven_pkg::VAL_W;
    localparam int                      CNTW = $clog2(VW);
    localparam logic [CNTW-1:0]         LAST = CNTW'(VW - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNTW-1:0]   r_cnt;
    logic [VW-1:0]     r_q;
    logic [VW-1:0]     r_rem;
    logic [VW-1:0]     r_den;
    logic [VW:0]       w_shift;
    logic [VW:0]       w_trial;

    assign w_shift = {r_rem, r_q[VW-1]};
    assign w_trial = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_trial[VW]) begin
                r_rem <= w_trial[VW-1:0];
                r_q   <= {r_q[VW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[VW-1:0];
                r_q   <= {r_q[VW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// File: rtl/core/dven_store.sv
// Factor table (prime, limit) and exponent digit memory, registered read.
// Depends on dven_pkg. Digits carry per-entry valid bits so restart clears them at once.
`default_nettype none

module dven_store #(
    parameter int MAX_FACTORS = dven_pkg::MAX_FACTORS_DEF
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire dven_pkg::t_store_ctl                        i_ctl,
    input  wire logic [((MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1)-1:0] i_tab_addr,
    input  wire logic [dven_pkg::VAL_W-1:0]                  i_prime,
    input  wire logic [dven_pkg::LIM_W-1:0]                  i_limit,
    input  wire logic [((MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1)-1:0] i_addr,
    input  wire logic [dven_pkg::LIM_W-1:0]                  i_digit,
    output logic      [dven_pkg::VAL_W-1:0]                  o_prime,
    output logic      [dven_pkg::LIM_W-1:0]                  o_limit,
    output logic      [dven_pkg::LIM_W-1:0]                  o_digit
);

    localparam int TW = dven_pkg::VAL_W + dven_pkg::LIM_W;

    logic [TW-1:0]               mem_tab [MAX_FACTORS];
    logic [dven_pkg::LIM_W-1:0]  mem_dig [MAX_FACTORS];
    logic [MAX_FACTORS-1:0]      r_valid;
    logic [TW-1:0]               r_tab_rd;
    logic [dven_pkg::LIM_W-1:0]  r_dig_rd;
    logic                        r_vld_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.tab_we) begin
            mem_tab[i_tab_addr] <= {i_prime, i_limit};
        end
        if (i_ctl.rd_en) begin
            r_tab_rd <= mem_tab[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.dig_we) begin
            mem_dig[i_addr] <= i_digit;
        end
        if (i_ctl.rd_en) begin
            r_dig_rd <= mem_dig[i_addr];
            r_vld_rd <= r_valid[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid <= '0;
        end else if (i_ctl.dig_we) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    assign o_prime = r_tab_rd[TW-1:dven_pkg::LIM_W];
    assign o_limit = r_tab_rd[dven_pkg::LIM_W-1:0];
    assign o_digit = r_vld_rd ? r_dig_rd : '0;    // untouched since restart reads as zero

endmodule

`default_nettype wire

// File: rtl/core/divisor_enumerator.sv
// Divisor enumerator: command interface (start/busy), one result request per command,
// strobed on o_done for a single cycle; the receiver cannot stall, so it must take every
// result as it appears. Load, restart and the unused code report on o_done in the cycle
// after they are accepted. An advance walks the exponent digits in the store, reading
// one digit at a time; every digit that wraps raises its prime to its limit on the shared
// 32x32 multiplier and then divides the divisor by that power in the bit-serial divider,
// and the digit that steps multiplies the divisor by its prime. A full wrap returns the
// multiple right after the last digit.
// Depends on dven_pkg, dven_regs, dven_store, dven_mul and dven_div.
`default_nettype none

module divisor_enumerator #(
    parameter int MAX_FACTORS = dven_pkg::MAX_FACTORS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [dven_pkg::CMD_W-1:0]    i_command,
    input  wire logic [dven_pkg::IDX_W-1:0]    i_factor_index,
    input  wire logic [dven_pkg::VAL_W-1:0]    i_prime_value,
    input  wire logic [dven_pkg::LIM_W-1:0]    i_exponent_limit,
    output logic                               o_done,
    output logic      [dven_pkg::VAL_W-1:0]    o_divisor,
    output logic                               o_wrapped,
    output logic                               o_overflow,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dven_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [dven_pkg::DATA_W-1:0]   pwdata,
    output logic      [dven_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam int AW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
    localparam int CW = $clog2(MAX_FACTORS + 1);
    localparam int VW = dven_pkg::VAL_W;
    localparam int LW = dven_pkg::LIM_W;

    localparam logic [dven_pkg::CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [dven_pkg::CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [dven_pkg::CMD_W-1:0] CMD_ADVANCE = 2'd2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_POW   = 3'd3;
    localparam logic [2:0] S_PWAIT = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DWAIT = 3'd6;
    localparam logic [2:0] S_MWAIT = 3'd7;

    logic [2:0]                 r_state;
    logic [CW-1:0]              r_k;
    logic [LW-1:0]              r_e;
    logic [VW-1:0]              r_pw;
    logic [VW-1:0]              r_divisor;
    logic                       r_ovf;
    logic                       r_done;
    logic                       r_wrapped;

    logic [dven_pkg::FC_W-1:0]  w_factor_count;
    logic [VW-1:0]              w_multiple;
    logic [CW-1:0]              w_n;
    logic                       w_accept;
    logic                       w_tab_ok;
    logic                       w_at_limit;
    dven_pkg::t_store_ctl       w_ctl;
    logic [VW-1:0]              s_prime;
    logic [LW-1:0]              s_limit;
    logic [LW-1:0]              s_digit;
    logic [LW-1:0]              w_dig_wr;
    logic                       w_mul_start;
    logic [VW-1:0]              w_mul_a;
    logic                       m_done;
    logic [VW-1:0]              m_prod;
    logic                       m_ovf;
    logic                       w_div_start;
    logic                       d_done;
    logic [VW-1:0]              d_quot;

    dven_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_prdata       (prdata),
        .o_factor_count (w_factor_count),
        .o_multiple     (w_multiple)
    );

    assign pready = 1'b1;

    // a count beyond the table is taken as the table size
    assign w_n = (32'(w_factor_count) > 32'(MAX_FACTORS)) ? CW'(MAX_FACTORS)
                                                          : CW'(w_factor_count);

    assign busy       = (r_state != S_IDLE);
    assign w_accept   = start && !busy;
    assign w_tab_ok   = 32'(i_factor_index) < 32'(MAX_FACTORS);
    assign w_at_limit = (s_digit >= s_limit);
    assign w_dig_wr   = w_at_limit ? '0 : s_digit + LW'(1);

    always_comb begin
        w_ctl.tab_we = w_accept && (i_command == CMD_LOAD) && w_tab_ok;
        w_ctl.clear  = w_accept && (i_command == CMD_RESTART);
        w_ctl.rd_en  = (r_state == S_READ) && (r_k != w_n);
        w_ctl.dig_we = (r_state == S_EVAL);
    end

    dven_store #(
        .MAX_FACTORS (MAX_FACTORS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_tab_addr (AW'(i_factor_index)),
        .i_prime    (i_prime_value),
        .i_limit    (i_exponent_limit),
        .i_addr     (r_k[AW-1:0]),
        .i_digit    (w_dig_wr),
        .o_prime    (s_prime),
        .o_limit    (s_limit),
        .o_digit    (s_digit)
    );

    assign w_mul_start = ((r_state == S_EVAL) && !w_at_limit)
                      || ((r_state == S_POW) && (r_e != '0));
    assign w_mul_a     = (r_state == S_POW) ? r_pw : r_divisor;

    dven_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (s_prime),
        .o_done  (m_done),
        .o_prod  (m_prod),
        .o_ovf   (m_ovf)
    );

    assign w_div_start = (r_state == S_DIV);

    dven_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_divisor),
        .i_den   (r_pw),
        .o_done  (d_done),
        .o_quot  (d_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= '0;
            r_divisor <= VW'(1);
            r_ovf     <= 1'b0;
            r_done    <= 1'b0;
            r_wrapped <= 1'b0;
        end else begin
            r_done    <= 1'b0;
            r_wrapped <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        priority case (i_command)
                            CMD_LOAD: begin
                                r_done <= 1'b1;
                            end
                            CMD_RESTART: begin
                                r_divisor <= w_multiple;
                                r_ovf     <= 1'b0;
                                r_done    <= 1'b1;
                            end
                            CMD_ADVANCE: begin
                                r_k     <= '0;
                                r_state <= S_READ;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (r_k == w_n) begin
                        // every digit wrapped
                        r_divisor <= w_multiple;
                        r_wrapped <= 1'b1;
                        r_done    <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_at_limit) begin
                        r_pw    <= VW'(1);
                        r_e     <= s_limit;
                        r_state <= S_POW;
                    end else begin
                        r_state <= S_MWAIT;
                    end
                end
                S_POW: begin
                    if (r_e != '0) begin
                        r_state <= S_PWAIT;
                    end else if (r_pw == '0) begin
                        // zero prime power leaves the divisor alone
                        r_k     <= r_k + CW'(1);
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_PWAIT: begin
                    if (m_done) begin
                        r_pw    <= m_prod;
                        r_ovf   <= r_ovf | m_ovf;
                        r_e     <= r_e - LW'(1);
                        r_state <= S_POW;
                    end
                end
                S_DIV: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (d_done) begin
                        r_divisor <= d_quot;
                        r_k       <= r_k + CW'(1);
                        r_state   <= S_READ;
                    end
                end
                S_MWAIT: begin
                    if (m_done) begin
                        r_divisor <= m_prod;
                        r_ovf     <= r_ovf | m_ovf;
                        r_done    <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_divisor  = r_divisor;
    assign o_wrapped  = r_wrapped;
    assign o_overflow = r_ovf;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking bench for divisor_enumerator: load/restart/advance requests, APB writes and
// readback, with an in-bench mixed-radix odometer predicting every strobed result.
// Depends on dven_pkg and the divisor_enumerator RTL; needs nothing else.
module tb;

    typedef enum logic [dven_pkg::CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_e;

    typedef logic [dven_pkg::VAL_W-1:0] val_t;
    typedef logic [dven_pkg::LIM_W-1:0] lim_t;

    localparam logic [dven_pkg::ADDR_W-1:0] ADDR_FACTOR_COUNT = 4'd0;
    localparam logic [dven_pkg::ADDR_W-1:0] ADDR_MULTIPLE     = 4'd8;
    localparam int   TABLE_DEPTH = dven_pkg::MAX_FACTORS_DEF;
    localparam val_t VMAX        = '1;
    localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;

    typedef struct {
        val_t divisor;
        logic wrapped;
        logic overflow;
    } divisor_res_t;

    typedef enum {ROW_REQ, ROW_REGS} row_kind_e;

    typedef struct {
        row_kind_e    kind;
        cmd_e         cmd;
        logic [3:0]   idx;
        val_t         prime;
        lim_t         lim;
        bit           fixed;
        divisor_res_t want;
        logic [4:0]   fc;
        val_t         mult;
    } dir_row_t;

    // DUT drive
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic [dven_pkg::CMD_W-1:0]    i_command = '0;
    logic [dven_pkg::IDX_W-1:0]    i_factor_index = '0;
    logic [dven_pkg::VAL_W-1:0]    i_prime_value = '0;
    logic [dven_pkg::LIM_W-1:0]    i_exponent_limit = '0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [dven_pkg::ADDR_W-1:0]   paddr = '0;
    logic [dven_pkg::DATA_W-1:0]   pwdata = '0;

    logic                          busy;
    logic                          o_done;
    logic [dven_pkg::VAL_W-1:0]    o_divisor;
    logic                          o_wrapped;
    logic                          o_overflow;
    logic [dven_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // Odometer predictor state
    val_t                   prime_tab [TABLE_DEPTH];
    lim_t                   limit_tab [TABLE_DEPTH];
    lim_t                   digits    [TABLE_DEPTH];
    bit [TABLE_DEPTH-1:0]   loaded;
    val_t                   cur_div;
    bit                     ovf_seen;
    logic [4:0]             fc_reg;
    val_t                   mult_reg;

    divisor_res_t    pending_divisors[$];
    dir_row_t        dir_rows[$];

    int              err_count = 0;
    int              n_requests = 0;
    int              n_advances = 0;
    int              n_settings = 0;
    int              n_wraps_seen = 0;
    int              n_ovf_seen = 0;
    int              idle_pct = 0;
    longint unsigned cycle_count = 0;

    always #6 i_clk = ~i_clk;

    divisor_enumerator DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_factor_index   (i_factor_index),
        .i_prime_value    (i_prime_value),
        .i_exponent_limit (i_exponent_limit),
        .o_done           (o_done),
        .o_divisor        (o_divisor),
        .o_wrapped        (o_wrapped),
        .o_overflow       (o_overflow),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        err_count++;
    endtask

    // Product clipped to 63 bits; any clip is sticky until a restart
    function automatic val_t scaled_mul(input val_t a, input val_t b);
        longint unsigned la, lb;
        la = {1'b0, a};
        lb = {1'b0, b};
        if (la != 0 && lb > {1'b0, VMAX} / la) begin
            ovf_seen = 1'b1;
            return VMAX;
        end
        return val_t'(la * lb);
    endfunction

    function automatic val_t prime_power(input val_t p, input lim_t e);
        val_t r;
        r = 1;
        for (int i = 0; i < e; i++) r = scaled_mul(r, p);
        return r;
    endfunction

    function automatic bit odometer_step();
        int   n, k;
        val_t pw;
        n = (fc_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(fc_reg);
        k = 0;
        // a digit above its limit (limit lowered later) wraps like one at its limit
        while (k < n && digits[k] >= limit_tab[k]) begin
            pw = prime_power(prime_tab[k], limit_tab[k]);
            digits[k] = '0;
            if (pw != 0) cur_div = cur_div / pw;
            k++;
        end
        if (k == n) begin
            cur_div = mult_reg;
            return 1'b1;
        end
        digits[k] = digits[k] + 1'b1;
        cur_div = scaled_mul(cur_div, prime_tab[k]);
        return 1'b0;
    endfunction

    function automatic divisor_res_t apply_command(input cmd_e cmd, input logic [3:0] idx,
                                                   input val_t prime, input lim_t lim);
        divisor_res_t res;
        bit           wrapped;
        wrapped = 1'b0;
        case (cmd)
            CMD_LOAD: begin
                prime_tab[idx] = prime;
                limit_tab[idx] = lim;
                loaded[idx] = 1'b1;
            end
            CMD_RESTART: begin
                foreach (digits[k]) digits[k] = '0;
                cur_div = mult_reg;
                ovf_seen = 1'b0;
            end
            CMD_ADVANCE: wrapped = odometer_step();
            default: ;
        endcase
        res.divisor = cur_div;
        res.wrapped = wrapped;
        res.overflow = ovf_seen;
        return res;
    endfunction

    function automatic dir_row_t req_row(input cmd_e c, input int idx, input val_t p,
                                         input lim_t l, input bit fixed, input val_t d,
                                         input logic w, input logic o);
        dir_row_t r;
        r.kind = ROW_REQ;
        r.cmd = c;
        r.idx = idx[3:0];
        r.prime = p;
        r.lim = l;
        r.fixed = fixed;
        r.want.divisor = d;
        r.want.wrapped = w;
        r.want.overflow = o;
        r.fc = '0;
        r.mult = '0;
        return r;
    endfunction

    function automatic dir_row_t regs_row(input logic [4:0] fc, input val_t mult);
        dir_row_t r;
        r = req_row(CMD_UNUSED, 0, '0, '0, 1'b0, '0, 1'b0, 1'b0);
        r.kind = ROW_REGS;
        r.fc = fc;
        r.mult = mult;
        return r;
    endfunction

    function automatic val_t random_prime();
        val_t p;
        int   sel;
        sel = $urandom_range(0, 9);
        case (sel)
            7: p = val_t'({$urandom, $urandom});
            8: p = VMAX - val_t'($urandom_range(0, 1000));
            9: p = val_t'($urandom_range(2, 1000000));
            default: begin
                case ($urandom_range(0, 6))
                    0: p = 2;
                    1: p = 3;
                    2: p = 5;
                    3: p = 7;
                    4: p = 11;
                    5: p = 13;
                    default: p = 17;
                endcase
            end
        endcase
        if (p < 2) p = 2;
        return p;
    endfunction

    function automatic lim_t random_limit();
        if ($urandom_range(0, 9) < 8) return lim_t'($urandom_range(0, 3));
        return lim_t'($urandom_range(4, 8));
    endfunction

    function automatic val_t random_multiple(input int sel);
        val_t m;
        case (sel)
            0: m = 1;
            1: m = VMAX;
            2: m = val_t'($urandom_range(2, 1000));
            default: m = val_t'({$urandom, $urandom});
        endcase
        if (m == 0) m = 1;
        return m;
    endfunction

    // One request: held until accepted, then predicted and queued
    task automatic send_request(input cmd_e cmd, input logic [3:0] idx, input val_t prime,
                                input lim_t lim, input bit fixed, input divisor_res_t want);
        divisor_res_t pred;
        start <= 1'b1;
        i_command <= cmd;
        i_factor_index <= idx;
        i_prime_value <= prime;
        i_exponent_limit <= lim;
        do @(posedge i_clk); while (busy !== 1'b0);
        pred = apply_command(cmd, idx, prime, lim);
        pending_divisors.push_back(fixed ? want : pred);
        n_requests++;
        if (cmd == CMD_ADVANCE) n_advances++;
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_divisors.size() != 0 || busy !== 1'b0);
    endtask

    task automatic apb_xfer(input bit wr, input logic [dven_pkg::ADDR_W-1:0] addr,
                            input logic [dven_pkg::DATA_W-1:0] wdata,
                            output logic [dven_pkg::DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
    endtask

    // Only called with the block idle; both registers written and read back
    task automatic program_settings(input logic [4:0] fc, input val_t mult);
        logic [dven_pkg::DATA_W-1:0] rd;
        repeat (4) @(posedge i_clk);
        apb_xfer(1'b1, ADDR_FACTOR_COUNT, {59'd0, fc}, rd);
        fc_reg = fc;
        apb_xfer(1'b1, ADDR_MULTIPLE, {1'b0, mult}, rd);
        mult_reg = mult;
        apb_xfer(1'b0, ADDR_FACTOR_COUNT, '0, rd);
        if (rd[4:0] !== fc)
            flag_mismatch($sformatf("factor_count readback %0d, wrote %0d", rd[4:0], fc));
        apb_xfer(1'b0, ADDR_MULTIPLE, '0, rd);
        if (rd[62:0] !== mult)
            flag_mismatch($sformatf("multiple readback %0d, wrote %0d", rd[62:0], mult));
        psel <= 1'b0;
        penable <= 1'b0;
        n_settings++;
    endtask

    task automatic send_random_request();
        cmd_e         cmd;
        int           r, n;
        logic [3:0]   idx;
        val_t         prime;
        lim_t         lim;
        divisor_res_t none;
        none = '{default: '0};
        r = $urandom_range(0, 99);
        if (r < 8) cmd = CMD_RESTART;
        else if (r < 20) cmd = CMD_LOAD;
        else if (r < 25) cmd = CMD_UNUSED;
        else cmd = CMD_ADVANCE;
        // unused fields still toggle; the block ignores them
        idx = 4'($urandom_range(0, 15));
        prime = random_prime();
        lim = random_limit();
        if (cmd == CMD_ADVANCE) begin
            n = (fc_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(fc_reg);
            // never let an advance read an entry that was never loaded
            for (int k = n - 1; k >= 0; k--) begin
                if (!loaded[k]) begin
                    cmd = CMD_LOAD;
                    idx = 4'(k);
                end
            end
        end
        send_request(cmd, idx, prime, lim, 1'b0, none);
    endtask

    // Results cannot be held off: every strobe is taken and checked here
    always @(posedge i_clk) begin
        divisor_res_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end else if (i_rst_n && o_done === 1'b1) begin
            if (pending_divisors.size() == 0) begin
                flag_mismatch($sformatf("unexpected result, divisor %0d", o_divisor));
            end else begin
                want = pending_divisors.pop_front();
                if (o_divisor !== want.divisor)
                    flag_mismatch($sformatf("divisor %0d, expected %0d", o_divisor,
                                            want.divisor));
                if (o_wrapped !== want.wrapped)
                    flag_mismatch($sformatf("wrapped %b, expected %b", o_wrapped,
                                            want.wrapped));
                if (o_overflow !== want.overflow)
                    flag_mismatch($sformatf("overflow %b, expected %b", o_overflow,
                                            want.overflow));
                if (o_wrapped === 1'b1) n_wraps_seen++;
                if (o_overflow === 1'b1) n_ovf_seen++;
            end
        end
    end

    initial begin
        divisor_res_t none;
        int           fc_list [8];
        int           gap;

        none = '{default: '0};
        fc_list = '{3, 16, 0, 31, 1, 6, 2, 20};
        fc_reg = 5'd1;
        mult_reg = 1;
        cur_div = 1;
        ovf_seen = 1'b0;
        loaded = '0;
        foreach (digits[k]) begin
            digits[k] = '0;
            prime_tab[k] = '0;
            limit_tab[k] = '0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset values, extremes, zero count, lowered limit, overflow, zero prime
        dir_rows.push_back(req_row(CMD_UNUSED, 0, '0, '0, 1'b1, 1, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_RESTART, 15, VMAX, '1, 1'b1, 1, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_LOAD, 0, 2, 2, 1'b1, 1, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_LOAD, 1, 3, 1, 1'b1, 1, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_LOAD, 2, VMAX, 63, 1'b1, 1, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_ADVANCE, 0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_ADVANCE, 0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_ADVANCE, 0, '0, '0, 1'b1, 1, 1'b1, 1'b0));
        dir_rows.push_back(regs_row(5'd0, 1));
        dir_rows.push_back(req_row(CMD_ADVANCE, 0, '0, '0, 1'b1, 1, 1'b1, 1'b0));
        dir_rows.push_back(regs_row(5'd2, 5));
        dir_rows.push_back(req_row(CMD_RESTART, 0, '0, '0, 1'b1, 5, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_ADVANCE, 0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_ADVANCE, 0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_LOAD, 0, 2, 1, 1'b1, 20, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_ADVANCE, 0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
        dir_rows.push_back(regs_row(5'd3, VMAX));
        dir_rows.push_back(req_row(CMD_RESTART, 0, '0, '0, 1'b1, VMAX, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_ADVANCE, 0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_UNUSED, 0, '0, '0, 1'b1, VMAX, 1'b0, 1'b1));
        dir_rows.push_back(req_row(CMD_ADVANCE, 0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_RESTART, 0, '0, '0, 1'b1, VMAX, 1'b0, 1'b0));
        dir_rows.push_back(regs_row(5'd2, 1));
        dir_rows.push_back(req_row(CMD_LOAD, 0, 0, 1, 1'b1, VMAX, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_RESTART, 0, '0, '0, 1'b1, 1, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_ADVANCE, 0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_ADVANCE, 0, '0, '0, 1'b0, '0, 1'b0, 1'b0));
        dir_rows.push_back(req_row(CMD_LOAD, 0, 3, 2, 1'b0, '0, 1'b0, 1'b0));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REGS) begin
                drain_results();
                program_settings(dir_rows[i].fc, dir_rows[i].mult);
            end else begin
                send_request(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].prime,
                             dir_rows[i].lim, dir_rows[i].fixed, dir_rows[i].want);
            end
        end

        // Fill the whole store with small entries so any count is safe to advance
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_request(CMD_LOAD, 4'(k), val_t'($urandom_range(2, 13)), random_limit(),
                         1'b0, none);

        // One digit run all the way to a large limit
        drain_results();
        program_settings(5'd1, val_t'($urandom_range(1, 50)));
        send_request(CMD_LOAD, 4'd0, val_t'($urandom_range(2, 3)), lim_t'($urandom_range(40, 63)),
                     1'b0, none);
        send_request(CMD_RESTART, 4'd0, '0, '0, 1'b0, none);
        repeat (70) send_request(CMD_ADVANCE, 4'(($urandom)), random_prime(), '1, 1'b0, none);
        send_request(CMD_LOAD, 4'd0, 2, 2, 1'b0, none);

        // Random phases: sender idle 0, 65 and 6 percent
        for (int p = 0; p < 8; p++) begin
            drain_results();
            program_settings(5'(fc_list[p]), random_multiple(p % 4));
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 65;
                default: idle_pct = 6;
            endcase
            send_request(CMD_RESTART, 4'd0, '0, '0, 1'b0, none);
            for (int i = 0; i < 250; i++) begin
                if (i == 125 || $urandom_range(0, 99) == 0) begin
                    // hold off until every queued result is back
                    drain_results();
                end else begin
                    gap = 0;
                    while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
                    pause_sender(gap);
                end
                send_random_request();
            end
        end

        drain_results();
        repeat (30) @(posedge i_clk);

        $display("Ran %0d requests (%0d advances) across %0d register settings;",
                 n_requests, n_advances, n_settings);
        $display("observed %0d wrapped and %0d overflow-flagged results.",
                 n_wraps_seen, n_ovf_seen);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", err_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
